### hdl/mfd_pkg.sv
// shared constants, event struct and label tables for the meter frame decoder
// no dependencies

package mfd_pkg;

  localparam int LABEL_MAX_DEF  = 8;
  localparam int DATA_MAX_DEF   = 12;
  localparam int MAX_GROUPS_DEF = 16;

  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 32;
  localparam int SLOTS   = 4;
  localparam int IDX_W   = 5;

  localparam logic [BYTE_W-1:0] CH_STX   = 8'h02;
  localparam logic [BYTE_W-1:0] CH_ETX   = 8'h03;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] SUM_INIT = 8'h20;
  localparam logic [BYTE_W-1:0] SUM_MASK = 8'h3F;

  // value slots
  localparam int SLOT_PAPP  = 0;
  localparam int SLOT_IINST = 1;
  localparam int SLOT_HCHC  = 2;
  localparam int SLOT_HCHP  = 3;

  typedef struct packed {
    logic               frame_open;  // first lf after stx
    logic               group_good;  // group closed with a good checksum
    logic [SLOTS-1:0]   slot_hit;    // which tracked label the group carried
    logic               frame_end;   // good etx
    logic               cksum_err;   // group closed with a bad checksum
    logic [VALUE_W-1:0] value;       // decimal value of the group
  } mfd_event_t;

  function automatic logic [IDX_W-1:0] name_len(input logic [1:0] slot);
    logic [IDX_W-1:0] len;
    case (slot)
      2'd1:    len = 5'd5;
      default: len = 5'd4;
    endcase
    return len;
  endfunction

  function automatic logic [BYTE_W-1:0] name_byte(input logic [1:0] slot,
                                                  input logic [IDX_W-1:0] idx);
    logic [BYTE_W-1:0] ch;
    ch = 8'h00;
    case (slot)
      2'd0: begin  // PAPP
        case (idx)
          5'd0:    ch = "P";
          5'd1:    ch = "A";
          5'd2:    ch = "P";
          5'd3:    ch = "P";
          default: ch = 8'h00;
        endcase
      end
      2'd1: begin  // IINST
        case (idx)
          5'd0:    ch = "I";
          5'd1:    ch = "I";
          5'd2:    ch = "N";
          5'd3:    ch = "S";
          5'd4:    ch = "T";
          default: ch = 8'h00;
        endcase
      end
      2'd2: begin  // HCHC
        case (idx)
          5'd0:    ch = "H";
          5'd1:    ch = "C";
          5'd2:    ch = "H";
          5'd3:    ch = "C";
          default: ch = 8'h00;
        endcase
      end
      default: begin  // HCHP
        case (idx)
          5'd0:    ch = "H";
          5'd1:    ch = "C";
          5'd2:    ch = "H";
          5'd3:    ch = "P";
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

endpackage

### hdl/mfd_parser.sv
// frame grammar tracker: phase, label match, data value, checksum, group count
// depends on mfd_pkg

module mfd_parser #(
  parameter int LABEL_MAX  = mfd_pkg::LABEL_MAX_DEF,
  parameter int DATA_MAX   = mfd_pkg::DATA_MAX_DEF,
  parameter int MAX_GROUPS = mfd_pkg::MAX_GROUPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [mfd_pkg::BYTE_W-1:0]  byte_in,
  output mfd_pkg::mfd_event_t         evt
);
  import mfd_pkg::*;

  localparam int LCW = $clog2(LABEL_MAX + 1);
  localparam int DCW = $clog2(DATA_MAX + 1);
  localparam int GCW = $clog2(MAX_GROUPS + 1);

  typedef enum logic [5:0] {
    PH_WAIT_STX = 6'b000001,
    PH_WAIT_LF  = 6'b000010,
    PH_LABEL    = 6'b000100,
    PH_DATA     = 6'b001000,
    PH_CKSUM    = 6'b010000,
    PH_AFTER    = 6'b100000
  } phase_t;

  phase_t               phase, phase_next;
  logic [LCW-1:0]       label_count, label_count_next;
  logic [DCW-1:0]       data_count, data_count_next;
  logic [BYTE_W-1:0]    running_sum, running_sum_next;
  logic [VALUE_W-1:0]   data_value, data_value_next;
  logic                 digits_ended, digits_ended_next;
  logic [BYTE_W-1:0]    received_checksum, received_checksum_next;
  logic                 checksum_seen, checksum_seen_next;
  logic [GCW-1:0]       group_count, group_count_next;
  logic [SLOTS-1:0]     prefix_ok, prefix_ok_next;
  logic [SLOTS-1:0]     label_hit, label_hit_next;
  logic [SLOTS-1:0]     byte_hit;
  logic [SLOTS-1:0]     full_hit;
  logic [BYTE_W-1:0]    expect_sum;
  logic                 error;

  // per-label prefix compare for the byte at the current label position
  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      byte_hit[k] = (IDX_W'(label_count) < name_len(2'(k))) &&
                    (byte_in == name_byte(2'(k), IDX_W'(label_count)));
      full_hit[k] = prefix_ok[k] && (IDX_W'(label_count) == name_len(2'(k)));
    end
  end

  assign expect_sum = (running_sum & SUM_MASK) + SUM_INIT;

  always_comb begin
    phase_next             = phase;
    label_count_next       = label_count;
    data_count_next        = data_count;
    running_sum_next       = running_sum;
    data_value_next        = data_value;
    digits_ended_next      = digits_ended;
    received_checksum_next = received_checksum;
    checksum_seen_next     = checksum_seen;
    group_count_next       = group_count;
    prefix_ok_next         = prefix_ok;
    label_hit_next         = label_hit;
    error                  = 1'b0;
    evt                    = '0;
    evt.value              = data_value;
    evt.slot_hit           = label_hit;

    case (phase)
      PH_WAIT_STX: begin
        if (byte_in == CH_STX) phase_next = PH_WAIT_LF;
      end
      PH_WAIT_LF: begin
        if (byte_in == CH_LF) begin
          evt.frame_open    = 1'b1;
          group_count_next  = '0;
          label_count_next  = '0;
          running_sum_next  = SUM_INIT;
          prefix_ok_next    = '1;
          phase_next        = PH_LABEL;
        end
      end
      PH_LABEL: begin
        if (byte_in == CH_SP) begin
          label_hit_next    = full_hit;
          data_count_next   = '0;
          data_value_next   = '0;
          digits_ended_next = 1'b0;
          phase_next        = PH_DATA;
        end else if (label_count < LCW'(LABEL_MAX)) begin
          label_count_next = label_count + 1'b1;
          running_sum_next = running_sum + byte_in;
          prefix_ok_next   = prefix_ok & byte_hit;
        end else begin
          error = 1'b1;
        end
      end
      PH_DATA: begin
        if (byte_in == CH_SP) begin
          checksum_seen_next = 1'b0;
          phase_next         = PH_CKSUM;
        end else if (data_count < DCW'(DATA_MAX)) begin
          data_count_next  = data_count + 1'b1;
          running_sum_next = running_sum + byte_in;
          if (!digits_ended && byte_in >= CH_ZERO && byte_in <= CH_NINE) begin
            // value * 10 + digit, wraps at 32 bits
            data_value_next = (data_value << 3) + (data_value << 1) +
                              VALUE_W'(byte_in - CH_ZERO);
          end else begin
            digits_ended_next = 1'b1;
          end
        end else begin
          error = 1'b1;
        end
      end
      PH_CKSUM: begin
        if (!checksum_seen) begin
          received_checksum_next = byte_in;
          checksum_seen_next     = 1'b1;
        end else if (byte_in == CH_CR) begin
          checksum_seen_next = 1'b0;
          if (expect_sum != received_checksum) begin
            evt.cksum_err = 1'b1;
            phase_next    = PH_AFTER;
          end else if (group_count >= GCW'(MAX_GROUPS)) begin
            error = 1'b1;
          end else begin
            evt.group_good   = 1'b1;
            group_count_next = group_count + 1'b1;
            phase_next       = PH_AFTER;
          end
        end else begin
          error = 1'b1;
        end
      end
      PH_AFTER: begin
        if (byte_in == CH_LF) begin
          label_count_next = '0;
          running_sum_next = SUM_INIT;
          prefix_ok_next   = '1;
          phase_next       = PH_LABEL;
        end else if (byte_in == CH_ETX) begin
          evt.frame_end = 1'b1;
          phase_next    = PH_WAIT_STX;
        end else begin
          error = 1'b1;
        end
      end
      default: error = 1'b1;
    endcase

    if (error) begin
      checksum_seen_next = 1'b0;
      phase_next         = PH_WAIT_STX;
    end

    if (!step) evt = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_WAIT_STX;
      label_count       <= '0;
      data_count        <= '0;
      running_sum       <= SUM_INIT;
      data_value        <= '0;
      digits_ended      <= 1'b0;
      received_checksum <= '0;
      checksum_seen     <= 1'b0;
      group_count       <= '0;
      prefix_ok         <= '0;
      label_hit         <= '0;
    end else if (step) begin
      phase             <= phase_next;
      label_count       <= label_count_next;
      data_count        <= data_count_next;
      running_sum       <= running_sum_next;
      data_value        <= data_value_next;
      digits_ended      <= digits_ended_next;
      received_checksum <= received_checksum_next;
      checksum_seen     <= checksum_seen_next;
      group_count       <= group_count_next;
      prefix_ok         <= prefix_ok_next;
      label_hit         <= label_hit_next;
    end
  end

endmodule

### hdl/mfd_value_store.sv
// per-frame staging and committed copies of the four tracked values
// depends on mfd_pkg

module mfd_value_store (
  input  logic                        clk,
  input  logic                        rst,
  input  mfd_pkg::mfd_event_t         evt,
  output logic [mfd_pkg::VALUE_W-1:0] committed [mfd_pkg::SLOTS]
);
  import mfd_pkg::*;

  logic [VALUE_W-1:0] staged [SLOTS];
  logic [SLOTS-1:0]   staged_seen;

  always_ff @(posedge clk) begin
    for (int k = 0; k < SLOTS; k++) begin
      if (evt.group_good && evt.slot_hit[k]) staged[k] <= evt.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      staged_seen <= '0;
      for (int k = 0; k < SLOTS; k++) committed[k] <= '1;
    end else begin
      if (evt.frame_open) begin
        staged_seen <= '0;
      end else if (evt.group_good) begin
        staged_seen <= staged_seen | evt.slot_hit;
      end
      if (evt.frame_end) begin
        for (int k = 0; k < SLOTS; k++) begin
          if (staged_seen[k]) committed[k] <= staged[k];
        end
      end
    end
  end

endmodule

### hdl/meter_frame_decoder_core.sv
// top level of the meter frame decoder: input register, parser, value store,
// result register; depends on mfd_pkg, mfd_parser, mfd_value_store

// Byte-serial decoder for electricity meter information frames. One byte is
// taken per transfer on the input channel and exactly one result transfer
// follows for every byte. Throughput is one byte per clock cycle; each byte
// passes first through the input register and then through the result
// register (one input register, one result register). All parsing is done
// in the single stage between them, so the only thing that slows the block
// down is out_stall, which backs up through the input register into
// in_stall. The four value outputs show the committed PAPP, IINST, HCHC and
// HCHP values as they stand after the byte of the current result; they read
// all ones until a well-formed frame carrying that label has closed. No
// clearing pass is needed after reset.

module meter_frame_decoder_core #(
  parameter int LABEL_MAX  = mfd_pkg::LABEL_MAX_DEF,
  parameter int DATA_MAX   = mfd_pkg::DATA_MAX_DEF,
  parameter int MAX_GROUPS = mfd_pkg::MAX_GROUPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mfd_pkg::BYTE_W-1:0]  rx_byte,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        frame_valid,
  output logic [mfd_pkg::VALUE_W-1:0] apparent_power,
  output logic [mfd_pkg::VALUE_W-1:0] instant_current,
  output logic [mfd_pkg::VALUE_W-1:0] offpeak_index,
  output logic [mfd_pkg::VALUE_W-1:0] peak_index,
  output logic                        checksum_error
);
  import mfd_pkg::*;

  // input register
  logic                 in_q_valid;
  logic [BYTE_W-1:0]    byte_q;

  // stage control
  logic                 out_free;
  logic                 step;
  logic                 in_take;

  mfd_event_t           evt;
  logic [VALUE_W-1:0]   committed [SLOTS];

  // the result register can load when it is empty or its content leaves now
  assign out_free = !out_valid || !out_stall;
  // a byte is parsed when it sits in the input register and the result
  // register can take its result
  assign step     = in_q_valid && out_free;
  // stall upstream only while a parsed byte cannot move on
  assign in_stall = in_q_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_take) byte_q <= rx_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (step) begin
      in_q_valid <= 1'b0;
    end
  end

  // grammar, checksum and decimal value tracking
  mfd_parser #(
    .LABEL_MAX  (LABEL_MAX),
    .DATA_MAX   (DATA_MAX),
    .MAX_GROUPS (MAX_GROUPS)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .byte_in (byte_q),
    .evt     (evt)
  );

  // staged values per frame, committed on a good etx; the committed copies
  // change only on a step, together with the result register, so they hold
  // still while a result is stalled
  mfd_value_store u_store (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt),
    .committed (committed)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      frame_valid    <= 1'b0;
      checksum_error <= 1'b0;
    end else if (step) begin
      out_valid      <= 1'b1;
      frame_valid    <= evt.frame_end;
      checksum_error <= evt.cksum_err;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign apparent_power  = committed[SLOT_PAPP];
  assign instant_current = committed[SLOT_IINST];
  assign offpeak_index   = committed[SLOT_HCHC];
  assign peak_index      = committed[SLOT_HCHP];

endmodule

### hdl/mfd_checker.sv
// port-level checks for meter_frame_decoder_core and the bind that attaches them
// depends on mfd_pkg and meter_frame_decoder_core

module mfd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        frame_valid,
  input logic [mfd_pkg::VALUE_W-1:0] apparent_power,
  input logic [mfd_pkg::VALUE_W-1:0] instant_current,
  input logic                        checksum_error
);

  // a byte is either a closing etx or a closing cr, never both
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(frame_valid && checksum_error))
    else $error("frame_valid and checksum_error together");

  // stalled result keeps its flags
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(frame_valid) &&
                                  $stable(checksum_error)))
    else $error("stalled result changed");

  // the committed PAPP and IINST values leave reset as the invalid mark
  a_reset_mark: assert property (@(posedge clk)
    $fell(rst) |-> (apparent_power == '1 && instant_current == '1))
    else $error("values not all ones after reset");

  // a committed PAPP or IINST value moves only with a result that closes a good frame
  a_commit_on_frame: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (!$stable(apparent_power) || !$stable(instant_current)))
      |-> (out_valid && frame_valid))
    else $error("value changed outside a frame end");

endmodule

bind meter_frame_decoder_core mfd_checker u_mfd_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .frame_valid     (frame_valid),
  .apparent_power  (apparent_power),
  .instant_current (instant_current),
  .checksum_error  (checksum_error)
);
